[hdl/fbalc_pkg.sv]
// ============================================================================
// First-fit block allocator package
// Shared types and codes for the allocator top level and its arithmetic unit.
// ============================================================================
package fbalc_pkg;

    typedef enum logic
    {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_RESIZE  = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_UNKNOWN   = 2'd3;

    localparam int OFFSET_W = 16;
    localparam int SIZE_W   = 17;

endpackage

[hdl/fbalc_alu.sv]
// ============================================================================
// Shared adder and subtractor
// One adder serves cursor advance, gap measurement and the arena-space check.
// ============================================================================
module fbalc_alu #(
    parameter int W = 18
) (
    input  fbalc_pkg::alu_op_t op,
    input  logic [W-1:0]       a,
    input  logic [W-1:0]       b,
    output logic [W-1:0]       y,
    output logic               borrow
);

    logic [W:0] full;

    always_comb
    begin
        if (op == fbalc_pkg::ALU_SUB)
        begin
            full = {1'b0, a} + {1'b0, ~b} + {{W{1'b0}}, 1'b1};
        end
        else
        begin
            full = {1'b0, a} + {1'b0, b};
        end
    end

    assign y = full[W-1:0];
    // For a subtraction the carry out is high when no borrow occurred.
    assign borrow = (op == fbalc_pkg::ALU_SUB) ? ~full[W] : 1'b0;

endmodule

[hdl/first_fit_block_allocator_top.sv]
// ============================================================================
// First-fit block allocator
// Sequenced allocate, release and resize over an address-ordered block table.
// ============================================================================
// Allocate scans the live entries in order and shifts entries up to make room
// for an insert; release and resize look up the block by its address, and a
// release then trims free entries from the end of the table.
// The single table read port and the one shared adder pace each of these steps.
// One request is in flight at a time; the next is taken once the result leaves.
// Reset clears the entry count and live bits at once; no clearing pass is run.
module first_fit_block_allocator_top #(
    parameter int ARENA_BYTES   = 65536,
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [16:0] size,
    input  logic [15:0] address,
    input  logic        address_is_null,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] result_address,
    output logic [1:0]  status
);

    localparam int IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW    = IW + 1;
    localparam int AB    = $clog2(ARENA_BYTES) + 1;
    localparam int CUR_W = (AB > 18) ? AB : 18;
    localparam int OW    = fbalc_pkg::OFFSET_W;
    localparam int SW    = fbalc_pkg::SIZE_W;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SCAN_ADV,
        S_APPEND,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_FIND_RD,
        S_FIND_EV,
        S_TRIM,
        S_FINISH
    } state_t;

    typedef enum logic [1:0]
    {
        JOB_ALLOC,
        JOB_RELEASE,
        JOB_RESIZE,
        JOB_MOVE_FREE
    } job_t;

    state_t                    state_reg, state_next;
    job_t                      job_reg, job_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             i_reg, i_next;
    logic [CW-1:0]             j_reg, j_next;
    logic [CUR_W-1:0]          cur_reg, cur_next;
    logic [TABLE_ENTRIES-1:0]  live_reg, live_next;
    logic                      out_valid_reg, out_valid_next;
    logic [OW-1:0]             res_addr_reg, res_addr_next;
    logic [1:0]                status_reg, status_next;
    logic [SW-1:0]             req_reg, req_next;
    logic [SW:0]               rl_reg, rl_next;
    logic [OW-1:0]             addr_reg, addr_next;

    // Table memory, one write and one registered read per cycle.
    logic [OW-1:0] off_mem [TABLE_ENTRIES];
    logic [SW-1:0] rl_mem  [TABLE_ENTRIES];
    logic [SW-1:0] req_mem [TABLE_ENTRIES];
    logic [OW-1:0] off_q;
    logic [SW-1:0] rl_q;
    logic [SW-1:0] req_q;

    logic          mem_we;
    logic          mem_re;
    logic [IW-1:0] wr_idx;
    logic [IW-1:0] rd_idx;
    logic [OW-1:0] wd_off;
    logic [SW-1:0] wd_rl;
    logic [SW-1:0] wd_req;

    fbalc_pkg::alu_op_t alu_op;
    logic [CUR_W-1:0]   alu_a;
    logic [CUR_W-1:0]   alu_b;
    logic [CUR_W-1:0]   alu_y;
    logic               alu_borrow;

    logic [SW:0]   size_plus3;
    logic [SW:0]   rl_in;
    logic [IW-1:0] i_idx;
    logic [IW-1:0] i_prev;
    logic [IW-1:0] j_idx;
    logic [IW-1:0] j_prev;
    logic [IW-1:0] last_idx;
    logic          alloc_done;
    logic          in_accept;

    fbalc_alu #(
        .W (CUR_W)
    ) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .y      (alu_y),
        .borrow (alu_borrow)
    );

    assign size_plus3 = {1'b0, size} + (SW+1)'(3);
    assign rl_in      = {size_plus3[SW:2], 2'b00};
    assign i_idx      = i_reg[IW-1:0];
    assign i_prev     = i_idx - IW'(1);
    assign j_idx      = j_reg[IW-1:0];
    assign j_prev     = j_idx - IW'(1);
    assign last_idx   = count_reg[IW-1:0] - IW'(1);

    assign in_ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_accept  = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            off_mem[wr_idx] <= wd_off;
            rl_mem[wr_idx]  <= wd_rl;
            req_mem[wr_idx] <= wd_req;
        end
        if (mem_re)
        begin
            off_q <= off_mem[rd_idx];
            rl_q  <= rl_mem[rd_idx];
            req_q <= req_mem[rd_idx];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cur_next       = cur_reg;
        live_next      = live_reg;
        out_valid_next = out_valid_reg;
        res_addr_next  = res_addr_reg;
        status_next    = status_reg;
        req_next       = req_reg;
        rl_next        = rl_reg;
        addr_next      = addr_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        wr_idx         = i_idx;
        rd_idx         = i_idx;
        wd_off         = cur_reg[OW-1:0];
        wd_rl          = rl_reg[SW-1:0];
        wd_req         = req_reg;
        alu_op         = fbalc_pkg::ALU_SUB;
        alu_a          = CUR_W'(off_q);
        alu_b          = cur_reg;
        alloc_done     = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    req_next      = size;
                    rl_next       = rl_in;
                    addr_next     = address;
                    res_addr_next = '0;
                    status_next   = fbalc_pkg::STATUS_OK;
                    i_next        = '0;
                    cur_next      = '0;
                    case (action)
                        fbalc_pkg::ACT_ALLOC:
                        begin
                            job_next   = JOB_ALLOC;
                            state_next = S_SCAN_RD;
                        end
                        fbalc_pkg::ACT_RELEASE:
                        begin
                            job_next   = JOB_RELEASE;
                            state_next = address_is_null ? S_TRIM : S_FIND_RD;
                        end
                        fbalc_pkg::ACT_RESIZE:
                        begin
                            job_next   = address_is_null ? JOB_ALLOC : JOB_RESIZE;
                            state_next = address_is_null ? S_SCAN_RD : S_FIND_RD;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                if (i_reg >= count_reg)
                begin
                    state_next = S_APPEND;
                end
                else if (!live_reg[i_idx])
                begin
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_SCAN_EV;
                end
            end

            S_SCAN_EV:
            begin
                // The adder measures the gap between the cursor and this block.
                if (rl_q == '0)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_SCAN_RD;
                end
                else if (!alu_borrow && (alu_y >= CUR_W'(rl_reg)))
                begin
                    if ((i_reg != '0) && !live_reg[i_prev])
                    begin
                        mem_we            = 1'b1;
                        wr_idx            = i_prev;
                        live_next[i_prev] = 1'b1;
                        alloc_done        = 1'b1;
                    end
                    else if (count_reg >= CW'(TABLE_ENTRIES))
                    begin
                        status_next = fbalc_pkg::STATUS_FULL;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        j_next     = count_reg;
                        state_next = S_SHIFT_RD;
                    end
                end
                else
                begin
                    state_next = S_SCAN_ADV;
                end
            end

            S_SCAN_ADV:
            begin
                alu_op     = fbalc_pkg::ALU_ADD;
                alu_b      = CUR_W'(rl_q);
                cur_next   = alu_y;
                i_next     = i_reg + CW'(1);
                state_next = S_SCAN_RD;
            end

            S_APPEND:
            begin
                // Room left in the arena behind the cursor.
                alu_a = CUR_W'(ARENA_BYTES);
                if (alu_borrow || (alu_y == '0) || (CUR_W'(rl_reg) > alu_y))
                begin
                    status_next = fbalc_pkg::STATUS_EXHAUSTED;
                    state_next  = S_FINISH;
                end
                else if (count_reg >= CW'(TABLE_ENTRIES))
                begin
                    status_next = fbalc_pkg::STATUS_FULL;
                    state_next  = S_FINISH;
                end
                else
                begin
                    mem_we                        = 1'b1;
                    wr_idx                        = count_reg[IW-1:0];
                    live_next[count_reg[IW-1:0]] = 1'b1;
                    count_next                    = count_reg + CW'(1);
                    alloc_done                    = 1'b1;
                end
            end

            S_SHIFT_RD:
            begin
                if (j_reg == i_reg)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    rd_idx     = j_prev;
                    state_next = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR:
            begin
                mem_we           = 1'b1;
                wr_idx           = j_idx;
                wd_off           = off_q;
                wd_rl            = rl_q;
                wd_req           = req_q;
                live_next[j_idx] = live_reg[j_prev];
                j_next           = j_reg - CW'(1);
                state_next       = S_SHIFT_RD;
            end

            S_INSERT:
            begin
                mem_we           = 1'b1;
                live_next[i_idx] = 1'b1;
                count_next       = count_reg + CW'(1);
                alloc_done       = 1'b1;
            end

            S_FIND_RD:
            begin
                if (i_reg >= count_reg)
                begin
                    if (job_reg == JOB_RESIZE)
                    begin
                        status_next = fbalc_pkg::STATUS_UNKNOWN;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_TRIM;
                    end
                end
                else if (!live_reg[i_idx])
                begin
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_FIND_EV;
                end
            end

            S_FIND_EV:
            begin
                if (off_q != addr_reg)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_FIND_RD;
                end
                else if (job_reg != JOB_RESIZE)
                begin
                    live_next[i_idx] = 1'b0;
                    state_next       = S_TRIM;
                end
                else if ({1'b0, rl_q} >= rl_reg)
                begin
                    // The block is large enough, so it shrinks in place.
                    mem_we        = 1'b1;
                    wd_off        = off_q;
                    res_addr_next = off_q;
                    state_next    = S_FINISH;
                end
                else
                begin
                    i_next     = '0;
                    cur_next   = '0;
                    state_next = S_SCAN_RD;
                end
            end

            S_TRIM:
            begin
                if ((count_reg != '0) && !live_reg[last_idx])
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (alloc_done)
        begin
            res_addr_next = cur_reg[OW-1:0];
            if (job_reg == JOB_RESIZE)
            begin
                // The new block is placed; now free the old one.
                job_next   = JOB_MOVE_FREE;
                i_next     = '0;
                state_next = S_FIND_RD;
            end
            else
            begin
                state_next = S_FINISH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= JOB_ALLOC;
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            cur_reg       <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
            res_addr_reg  <= '0;
            status_reg    <= fbalc_pkg::STATUS_OK;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            count_reg     <= count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            cur_reg       <= cur_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
            res_addr_reg  <= res_addr_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        rl_reg   <= rl_next;
        addr_reg <= addr_next;
    end

    assign out_valid      = out_valid_reg;
    assign result_address = res_addr_reg;
    assign status         = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_ENTRIES))
        else $error("entry count exceeds table size");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != fbalc_pkg::STATUS_OK)) |-> (result_address == '0))
        else $error("failed request returned a nonzero address");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ready)
        else $error("allocator ready again right after taking a request");

endmodule

[sim/tb_first_fit_block_allocator_top.sv]
// ============================================================================
// First-fit block allocator testbench
// Drives allocate, release and resize requests with random idling on both
// handshakes and checks every result against a behavioral table model.
// ============================================================================
`timescale 1ns / 1ps

module tb_first_fit_block_allocator_top;

    localparam int ARENA = 65536;
    localparam int DEPTH = 64;
    localparam int STALL_LIMIT = 20000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  stat;
    } alloc_result_t;

    // Table model plus the queue of results it has worked out.
    class alloc_scoreboard;
        logic [15:0] offs [DEPTH];
        bit          live [DEPTH];
        logic [16:0] rlen [DEPTH];
        logic [16:0] qlen [DEPTH];
        int          count;
        alloc_result_t pending [$];
        int          mismatches;
        int          checked;

        function void clear_table();
            for (int k = 0; k < DEPTH; k++)
            begin
                offs[k] = '0;
                live[k] = 0;
                rlen[k] = '0;
                qlen[k] = '0;
            end
            count = 0;
            mismatches = 0;
            checked = 0;
        endfunction

        function void place(int k, int o, int rl, int rq);
            offs[k] = o[15:0];
            live[k] = 1;
            rlen[k] = rl[16:0];
            qlen[k] = rq[16:0];
        endfunction

        function logic [1:0] allocate(int rq, output int where);
            int rl;
            int cur;
            rl = (rq + 3) / 4 * 4;
            cur = 0;
            where = 0;
            for (int k = 0; k < count; k++)
            begin
                if (!live[k] || rlen[k] == 0)
                    continue;
                if (int'(offs[k]) >= cur && int'(offs[k]) - cur >= rl)
                begin
                    if (k > 0 && !live[k-1])
                        place(k - 1, cur, rl, rq);
                    else
                    begin
                        if (count >= DEPTH)
                            return fbalc_pkg::STATUS_FULL;
                        for (int j = count; j > k; j--)
                        begin
                            offs[j] = offs[j-1];
                            live[j] = live[j-1];
                            rlen[j] = rlen[j-1];
                            qlen[j] = qlen[j-1];
                        end
                        count++;
                        place(k, cur, rl, rq);
                    end
                    where = cur;
                    return fbalc_pkg::STATUS_OK;
                end
                cur = int'(offs[k]) + int'(rlen[k]);
            end
            if (cur >= ARENA || rl > ARENA - cur)
                return fbalc_pkg::STATUS_EXHAUSTED;
            if (count >= DEPTH)
                return fbalc_pkg::STATUS_FULL;
            place(count, cur, rl, rq);
            count++;
            where = cur;
            return fbalc_pkg::STATUS_OK;
        endfunction

        function void trim();
            while (count > 0 && !live[count-1])
                count--;
        endfunction

        function void free_block(logic [15:0] a);
            for (int k = 0; k < count; k++)
            begin
                if (live[k] && offs[k] == a)
                begin
                    live[k] = 0;
                    rlen[k] = '0;
                    qlen[k] = '0;
                    break;
                end
            end
            trim();
        endfunction

        function int find(logic [15:0] a);
            for (int k = 0; k < count; k++)
                if (live[k] && offs[k] == a)
                    return k;
            return -1;
        endfunction

        function void note_request(logic [1:0] act, logic [16:0] sz,
                                   logic [15:0] a, logic nul);
            int where;
            int k;
            int rl;
            logic [1:0] st;
            alloc_result_t r;
            where = 0;
            st = fbalc_pkg::STATUS_OK;
            if (act == fbalc_pkg::ACT_ALLOC || (act == fbalc_pkg::ACT_RESIZE && nul))
                st = allocate(int'(sz), where);
            else if (act == fbalc_pkg::ACT_RELEASE)
            begin
                if (!nul)
                    free_block(a);
                else
                    trim();
            end
            else if (act == fbalc_pkg::ACT_RESIZE)
            begin
                rl = (int'(sz) + 3) / 4 * 4;
                k = find(a);
                if (k < 0)
                    st = fbalc_pkg::STATUS_UNKNOWN;
                else if (int'(rlen[k]) >= rl)
                begin
                    rlen[k] = rl[16:0];
                    qlen[k] = sz;
                    where = offs[k];
                end
                else
                begin
                    st = allocate(int'(sz), where);
                    if (st == fbalc_pkg::STATUS_OK)
                        free_block(a);
                end
            end
            if (st != fbalc_pkg::STATUS_OK)
                where = 0;
            r.addr = where[15:0];
            r.stat = st;
            pending.push_back(r);
        endfunction

        function void check_result(logic [15:0] a, logic [1:0] st);
            alloc_result_t e;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result addr=%0d status=%0d", a, st);
                return;
            end
            e = pending.pop_front();
            if (e.addr !== a || e.stat !== st)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: result %0d expected addr=%0d status=%0d,",
                              " got addr=%0d status=%0d"},
                             checked, e.addr, e.stat, a, st);
            end
        endfunction

        // Picks an address of a live block, if there is one.
        function logic [15:0] some_live(output bit ok);
            int idx [$];
            for (int k = 0; k < count; k++)
                if (live[k])
                    idx.push_back(k);
            ok = idx.size() > 0;
            if (!ok)
                return '0;
            return offs[idx[$urandom_range(idx.size() - 1)]];
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [16:0] size;
    logic [15:0] address;
    logic        address_is_null;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] result_address;
    logic [1:0]  status;

    alloc_scoreboard sb;
    bit   quiet;
    int   idle_cycles;
    int   stall_left;
    int   n_sent;
    int   n_ok;
    int   n_fail;

    first_fit_block_allocator_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .size            (size),
        .address         (address),
        .address_is_null (address_is_null),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_address  (result_address),
        .status          (status)
    );

    always #10 clk = ~clk;

    task automatic send_request(logic [1:0] act, logic [16:0] sz,
                                logic [15:0] a, logic nul);
        int gap;
        if (!quiet && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(15, 1);
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        action          <= act;
        size            <= sz;
        address         <= a;
        address_is_null <= nul;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(act, sz, a, nul);
        n_sent++;
        in_valid <= 1'b0;
        // The block is busy after a request, so this edge costs nothing.
        @(posedge clk);
    endtask

    // Waits for the previous result so that the model sees the live table.
    task automatic drain();
        while (sb.pending.size() > 0)
            @(posedge clk);
    endtask

    task automatic random_request();
        int pick;
        bit ok;
        logic [15:0] a;
        logic [16:0] sz;
        drain();
        a = sb.some_live(ok);
        pick = $urandom_range(99);
        case ($urandom_range(9))
            0: sz = 17'($urandom_range(65536));
            1: sz = 17'($urandom);
            default: sz = 17'($urandom_range(1200));
        endcase
        if (pick < 45)
            send_request(fbalc_pkg::ACT_ALLOC, sz, 16'($urandom), 1'($urandom_range(1)));
        else if (pick < 75)
            send_request(fbalc_pkg::ACT_RELEASE, sz, ok && pick < 72 ? a : 16'($urandom),
                         pick == 74);
        else if (pick < 97)
            send_request(fbalc_pkg::ACT_RESIZE, sz, ok && pick < 93 ? a : 16'($urandom),
                         pick == 96);
        else
            send_request(ACT_UNUSED, sz, 16'($urandom), 1'($urandom_range(1)));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(result_address, status);
            if (status == fbalc_pkg::STATUS_OK)
                n_ok++;
            else
                n_fail++;
        end
        // Output stalls come in random bursts, except in the quiet phase.
        if (quiet)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(7) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(14, 0);
        end
        else
            out_ready <= 1'b1;
    end

    // Stall watchdog: counts cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
            $display("tb_first_fit_block_allocator_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        int burst;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = fbalc_pkg::ACT_ALLOC;
        size = '0;
        address = '0;
        address_is_null = 1'b0;
        out_ready = 1'b0;
        quiet = 0;
        idle_cycles = 0;
        stall_left = 0;
        n_sent = 0;
        n_ok = 0;
        n_fail = 0;
        sb = new();
        sb.clear_table();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero length, odd lengths, a hole refilled, exhaustion, resizes, null and unknown addresses.
        send_request(fbalc_pkg::ACT_ALLOC, 17'd0, 16'hFFFF, 1'b0);
        send_request(fbalc_pkg::ACT_ALLOC, 17'd5, 16'd0, 1'b0);
        send_request(fbalc_pkg::ACT_ALLOC, 17'd1, 16'd0, 1'b1);
        send_request(fbalc_pkg::ACT_ALLOC, 17'd100, 16'd0, 1'b0);
        send_request(fbalc_pkg::ACT_RELEASE, 17'd0, 16'd8, 1'b0);
        send_request(fbalc_pkg::ACT_ALLOC, 17'd3, 16'd0, 1'b0);
        send_request(fbalc_pkg::ACT_ALLOC, 17'd65536, 16'd0, 1'b0);
        send_request(fbalc_pkg::ACT_ALLOC, 17'h1FFFF, 16'd0, 1'b0);
        send_request(fbalc_pkg::ACT_RESIZE, 17'd2, 16'd0, 1'b0);
        send_request(fbalc_pkg::ACT_RESIZE, 17'd400, 16'd0, 1'b0);
        send_request(fbalc_pkg::ACT_RESIZE, 17'd8, 16'd1234, 1'b0);
        send_request(fbalc_pkg::ACT_RESIZE, 17'd16, 16'hFFFF, 1'b1);
        send_request(fbalc_pkg::ACT_RESIZE, 17'd65536, 16'd0, 1'b0);
        send_request(fbalc_pkg::ACT_RELEASE, 17'd0, 16'hFFFF, 1'b0);
        send_request(fbalc_pkg::ACT_RELEASE, 17'd0, 16'd0, 1'b1);
        send_request(ACT_UNUSED, 17'h1FFFF, 16'hFFFF, 1'b1);
        drain();
        // Fill the table to its limit, then overflow it.
        for (int k = 0; k < DEPTH + 2; k++)
            send_request(fbalc_pkg::ACT_ALLOC, 17'd4, 16'd0, 1'b0);
        send_request(fbalc_pkg::ACT_RELEASE, 17'd0, 16'd0, 1'b0);
        send_request(fbalc_pkg::ACT_ALLOC, 17'd8, 16'd0, 1'b0);
        send_request(fbalc_pkg::ACT_ALLOC, 17'd4, 16'd0, 1'b0);
        drain();
        for (int k = 0; k < DEPTH; k++)
            send_request(fbalc_pkg::ACT_RELEASE, 17'd0, 16'(k * 4), 1'b0);

        for (int k = 0; k < 1400; k++)
        begin
            if (k == 1250)
                quiet = 1;
            random_request();
            // Occasionally flush the table to keep exploring shallow states.
            if ($urandom_range(299) == 0)
            begin
                drain();
                burst = sb.count;
                for (int j = 0; j < burst; j++)
                    if (sb.live[j])
                        send_request(fbalc_pkg::ACT_RELEASE, 17'd0, sb.offs[j], 1'b0);
            end
        end
        drain();
        repeat (300) @(posedge clk);
        $display("Sent %0d requests: %0d results ok, %0d with error status.",
                 n_sent, n_ok, n_fail);
        $display("Mismatches: %0d, results left over: %0d.",
                 sb.mismatches, sb.pending.size());
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb_first_fit_block_allocator_top: done, clean");
        else
            $display("tb_first_fit_block_allocator_top: done, errors");
        $finish;
    end

endmodule

[files.f]
hdl/fbalc_pkg.sv
hdl/fbalc_alu.sv
hdl/first_fit_block_allocator_top.sv
sim/tb_first_fit_block_allocator_top.sv
